>>> sv/pmc_pkg.sv
// pmc_pkg: shared types and constants of the ps/2 mouse packet cursor block
// no dependencies; compile first

package pmc_pkg;

  // header byte bit positions
  localparam int unsigned HdrOvfYBit  = 7;
  localparam int unsigned HdrOvfXBit  = 6;
  localparam int unsigned HdrSignYBit = 5;
  localparam int unsigned HdrSignXBit = 4;
  localparam int unsigned HdrRightBit = 1;
  localparam int unsigned HdrLeftBit  = 0;

  localparam logic [7:0] ColReset     = 8'd40;
  localparam logic [7:0] RowReset     = 8'd25 - 8'd13;
  localparam logic [7:0] ColumnsReset = 8'd80;
  localparam logic [7:0] RowsReset    = 8'd25;

  // configuration register indexes
  localparam logic [7:0] CfgColumns = 8'd0;
  localparam logic [7:0] CfgRows    = 8'd1;

  // packet byte position
  localparam logic [1:0] IdxHeader = 2'd0;
  localparam logic [1:0] IdxDx     = 2'd1;
  localparam logic [1:0] IdxDy     = 2'd2;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvStart = 2'd1,
    EvEnd   = 2'd2,
    EvPaste = 2'd3
  } sel_ev_e;

  // one assembled packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  // cursor unit result
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    sel_ev_e    ev;
  } res_t;

  // screen limits
  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows;
  } limits_t;

endpackage

>>> sv/pmc_if.sv
// pmc_if: valid/ready channel interfaces for input bytes, results and config writes
// depends on nothing; compile after pmc_pkg

interface pmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_aux;
  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface pmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic [1:0] select_event;
  modport source (output valid, output cursor_col, output cursor_row,
                  output select_event, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input select_event, output ready);
endinterface

interface pmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/pmc_packet_asm.sv
// pmc_packet_asm: gathers auxiliary bytes into three-byte packets
// depends on pmc_pkg

module pmc_packet_asm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  input  logic          aux_i,
  output logic          done_o,
  output pmc_pkg::pkt_t pkt_o
);
  import pmc_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] dx_q, dx_d;
  logic       use_byte;

  assign use_byte = take_i && aux_i;

  always_comb begin
    idx_d  = idx_q;
    hdr_d  = hdr_q;
    dx_d   = dx_q;
    done_o = 1'b0;
    if (use_byte) begin
      if (idx_q == IdxHeader) begin
        // overflow header dropped, stay on first byte
        if (!byte_i[HdrOvfYBit] && !byte_i[HdrOvfXBit]) begin
          hdr_d = byte_i;
          idx_d = IdxDx;
        end
      end else if (idx_q == IdxDx) begin
        dx_d  = byte_i;
        idx_d = IdxDy;
      end else begin
        done_o = 1'b1;
        idx_d  = IdxHeader;
      end
    end
  end

  assign pkt_o = '{header: hdr_q, dx: dx_q, dy: byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IdxHeader;
      hdr_q <= 8'd0;
      dx_q  <= 8'd0;
    end else begin
      idx_q <= idx_d;
      hdr_q <= hdr_d;
      dx_q  <= dx_d;
    end
  end

endmodule

>>> sv/pmc_cursor.sv
// pmc_cursor: button machine and bounded cursor move for one packet
// depends on pmc_pkg

module pmc_cursor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             done_i,
  input  pmc_pkg::pkt_t    pkt_i,
  input  pmc_pkg::limits_t lim_i,
  output pmc_pkg::res_t    res_o
);
  import pmc_pkg::*;

  logic       left_q, left_d;
  logic       sel_q, sel_d;
  logic       have_q, have_d;
  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  sel_ev_e    ev;

  logic signed [9:0] dx9, dy9, col_nx, row_nx;
  logic              col_ok, row_ok;

  // button machine
  always_comb begin
    left_d = left_q;
    sel_d  = sel_q;
    have_d = have_q;
    ev     = EvNone;
    if (pkt_i.header[HdrLeftBit]) begin
      if (!left_q) begin
        left_d = 1'b1;
      end else if (!sel_q) begin
        sel_d = 1'b1;
        ev    = EvStart;
      end
    end else if (pkt_i.header[HdrRightBit]) begin
      if (have_q) ev = EvPaste;
    end else begin
      left_d = 1'b0;
      if (sel_q) begin
        sel_d  = 1'b0;
        have_d = 1'b1;
        ev     = EvEnd;
      end
    end
  end

  // 9-bit deltas, positive y moves up
  assign dx9    = {pkt_i.header[HdrSignXBit], pkt_i.header[HdrSignXBit], pkt_i.dx};
  assign dy9    = {pkt_i.header[HdrSignYBit], pkt_i.header[HdrSignYBit], pkt_i.dy};
  assign col_nx = $signed({2'b00, col_q}) + dx9;
  assign row_nx = $signed({2'b00, row_q}) - dy9;
  assign col_ok = !col_nx[9] && (col_nx[8:0] < {1'b0, lim_i.columns});
  assign row_ok = !row_nx[9] && (row_nx[8:0] < {1'b0, lim_i.rows});
  assign col_d  = col_ok ? col_nx[7:0] : col_q;
  assign row_d  = row_ok ? row_nx[7:0] : row_q;

  assign res_o = '{col: col_d, row: row_d, ev: ev};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 1'b0;
      sel_q  <= 1'b0;
      have_q <= 1'b0;
      col_q  <= ColReset;
      row_q  <= RowReset;
    end else if (done_i) begin
      left_q <= left_d;
      sel_q  <= sel_d;
      have_q <= have_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

`ifndef SYNTH
  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |=> have_q) else $error("selection flag cleared");
  a_sel_needs_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> left_q) else $error("selecting without left held");
  a_paste_needs_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && ev == EvPaste) |-> have_q) else $error("paste without selection");
`endif

endmodule

>>> sv/ps2_mouse_packet_cursor_core.sv
// ps2_mouse_packet_cursor_core: top level, input stage, config and result register
// depends on pmc_pkg, pmc_if, pmc_packet_asm, pmc_cursor
//
//  channel | dir | payload                                  | word
//  in_i    | in  | data_byte[7:0], from_aux                 | one controller byte
//  out_o   | out | cursor_col[7:0], cursor_row[7:0], sel[1:0] | one per full packet
//  cfg_i   | in  | index[7:0], data[7:0]                    | one register write
//
// one byte is accepted per cycle while the result is not stalled; a result is offered
// once the packet's third byte has passed the input register, then the result register
// reset: columns 80, rows 25, cursor at 40,12, assembly at the first byte
// a stalled result holds the input stage, and that stage holds in_i.ready
// config writes are always ready and take effect at once

module ps2_mouse_packet_cursor_core (
  input  logic clk_i,
  input  logic rst_ni,
  pmc_in_if.sink    in_i,
  pmc_out_if.source out_o,
  pmc_cfg_if.sink   cfg_i
);
  import pmc_pkg::*;

  // screen limits
  limits_t    lim_q;

  // input register
  logic       s1_vld_q;
  logic [7:0] s1_byte_q;
  logic       s1_aux_q;
  logic       s1_adv;

  // result register
  logic       out_vld_q, out_vld_d;
  res_t       out_q;

  logic       pkt_done;
  pkt_t       pkt;
  res_t       res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '{columns: ColumnsReset, rows: RowsReset};
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgColumns) lim_q.columns <= cfg_i.data;
      if (cfg_i.index == CfgRows)    lim_q.rows    <= cfg_i.data;
    end
  end

  // input stage moves on whenever the result slot is free or being emptied
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_aux_q  <= in_i.from_aux;
    end
  end

  pmc_packet_asm u_asm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (s1_adv),
    .byte_i (s1_byte_q),
    .aux_i  (s1_aux_q),
    .done_o (pkt_done),
    .pkt_o  (pkt)
  );

  pmc_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .done_i (pkt_done),
    .pkt_i  (pkt),
    .lim_i  (lim_q),
    .res_o  (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (pkt_done)         out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_done) out_q <= res;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.cursor_col   = out_q.col;
  assign out_o.cursor_row   = out_q.row;
  assign out_o.select_event = out_q.ev;

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for ps2_mouse_packet_cursor_core
// depends on pmc_pkg, pmc_if and the block's rtl; a scoreboard class tracks
// packet assembly, the button machine and the bounded cursor

module testbench;
  import pmc_pkg::*;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 7;
  // the result follows the third byte through the input and result registers; spare cycles settle it
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 8;
  // receiver hold-off used to fill the block and stall its input
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned BurstPackets = 60;
  // cycles with no word moving on any channel before the run is abandoned
  localparam int unsigned IdleLimit    = 4000;

  // predictor and store of expected cursor words
  class cursor_scoreboard;
    res_t        cursor_q[$];
    int unsigned errors;
    limits_t     limits;
    logic [1:0]  byte_pos;
    logic [7:0]  header;
    logic [7:0]  dx;
    bit          left_held;
    bit          selecting;
    bit          have_selection;
    logic [7:0]  col;
    logic [7:0]  row;

    function new();
      errors         = 0;
      limits.columns = ColumnsReset;
      limits.rows    = RowsReset;
      byte_pos       = IdxHeader;
      header         = '0;
      dx             = '0;
      left_held      = 1'b0;
      selecting      = 1'b0;
      have_selection = 1'b0;
      col            = ColReset;
      row            = RowReset;
    endfunction

    function void write_limit(logic [7:0] index, logic [7:0] value);
      if (index == CfgColumns) limits.columns = value;
      else if (index == CfgRows) limits.rows = value;
    endfunction

    function int delta9(logic [7:0] low, logic negative);
      return negative ? int'(low) - 256 : int'(low);
    endfunction

    // an axis moves only if it lands inside 0 .. limit-1
    function logic [7:0] step_axis(logic [7:0] pos, int delta, logic [7:0] limit);
      int nxt_pos;
      nxt_pos = int'(pos) + delta;
      if (nxt_pos >= 0 && nxt_pos < int'(limit)) return nxt_pos[7:0];
      return pos;
    endfunction

    function void note_input(logic [7:0] b, logic aux);
      res_t r;
      if (!aux) return;
      if (byte_pos == IdxHeader) begin
        if (b[HdrOvfYBit] || b[HdrOvfXBit]) return;
        header   = b;
        byte_pos = IdxDx;
        return;
      end
      if (byte_pos == IdxDx) begin
        dx       = b;
        byte_pos = IdxDy;
        return;
      end
      byte_pos = IdxHeader;
      r.ev     = EvNone;
      if (header[HdrLeftBit]) begin
        if (!left_held) begin
          left_held = 1'b1;
        end else if (!selecting) begin
          selecting = 1'b1;
          r.ev      = EvStart;
        end
      end else if (header[HdrRightBit]) begin
        if (have_selection) r.ev = EvPaste;
      end else begin
        left_held = 1'b0;
        if (selecting) begin
          selecting      = 1'b0;
          have_selection = 1'b1;
          r.ev           = EvEnd;
        end
      end
      col   = step_axis(col, delta9(dx, header[HdrSignXBit]), limits.columns);
      // positive y moves up the screen
      row   = step_axis(row, -delta9(b, header[HdrSignYBit]), limits.rows);
      r.col = col;
      r.row = row;
      cursor_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] c, logic [7:0] r, logic [1:0] ev);
      res_t exp_w;
      if (cursor_q.size() == 0) begin
        $display("%0t: unexpected cursor word col %0d row %0d event %0d",
                 $time, c, r, ev);
        errors++;
        return;
      end
      exp_w = cursor_q.pop_front();
      if (exp_w.col !== c) begin
        $display("%0t: cursor_col mismatch, expected %0d, actual %0d", $time, exp_w.col, c);
        errors++;
      end
      if (exp_w.row !== r) begin
        $display("%0t: cursor_row mismatch, expected %0d, actual %0d", $time, exp_w.row, r);
        errors++;
      end
      if (2'(exp_w.ev) !== ev) begin
        $display("%0t: select_event mismatch, expected %0d, actual %0d",
                 $time, 2'(exp_w.ev), ev);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return cursor_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pmc_in_if  in_if ();
  pmc_out_if out_if ();
  pmc_cfg_if cfg_if ();

  ps2_mouse_packet_cursor_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cursor_scoreboard sb = new();

  int unsigned aux_items   = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;
  bit          burst_mode  = 1'b0;
  bit          no_idle     = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  // gap lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // small deltas keep the cursor roaming; now and then a full 9-bit value
  function automatic logic [8:0] random_delta();
    int v;
    if ($urandom_range(9) < 8) v = int'($urandom_range(8)) - 4;
    else v = int'($urandom_range(511)) - 256;
    return v[8:0];
  endfunction

  function automatic logic [7:0] make_header(logic left, logic right, logic sx, logic sy);
    logic [7:0] h;
    h              = 8'h08;
    h[HdrLeftBit]  = left;
    h[HdrRightBit] = right;
    h[HdrSignXBit] = sx;
    h[HdrSignYBit] = sy;
    return h;
  endfunction

  // one controller byte; called and left at a falling edge, valid stays high
  // so that back-to-back words need no second assignment
  task automatic send_byte(input logic [7:0] b, input logic aux);
    int unsigned gap;
    gap = (burst_mode || no_idle) ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.from_aux  = aux;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(b, aux);
    if (aux) aux_items++;
    @(negedge clk_i);
  endtask

  task automatic send_packet(input logic [7:0] h, input logic [7:0] dxb, input logic [7:0] dyb);
    send_byte(h, 1'b1);
    send_byte(dxb, 1'b1);
    send_byte(dyb, 1'b1);
  endtask

  // well-formed packet, buttons biased so selections start, end and paste
  task automatic send_random_packet();
    int unsigned btn;
    logic [8:0]  dx9;
    logic [8:0]  dy9;
    logic [7:0]  h;
    btn            = $urandom_range(99);
    dx9            = random_delta();
    dy9            = random_delta();
    h              = 8'($urandom_range(255));
    h[HdrOvfYBit]  = 1'b0;
    h[HdrOvfXBit]  = 1'b0;
    h[HdrLeftBit]  = (btn < 45) || (btn >= 90);
    h[HdrRightBit] = (btn >= 70);
    h[HdrSignXBit] = dx9[8];
    h[HdrSignYBit] = dy9[8];
    send_packet(h, dx9[7:0], dy9[7:0]);
  endtask

  // mostly packets; some ignored bytes, stray aux bytes and dropped headers
  task automatic send_random_item();
    int unsigned kind;
    int unsigned ovf;
    logic [7:0]  h;
    kind = $urandom_range(99);
    if (kind < 5) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if (kind < 13) begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end else if (kind < 17) begin
      ovf           = $urandom_range(1, 3);
      h             = 8'($urandom_range(255));
      h[HdrOvfYBit] = ovf[1];
      h[HdrOvfXBit] = ovf[0];
      send_byte(h, 1'b1);
      send_random_packet();
    end else begin
      send_random_packet();
    end
  endtask

  // stop offering, let every expected word arrive and the pipe settle
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limits(input logic [7:0] cols, input logic [7:0] rows);
    cfg_if.valid = 1'b1;
    cfg_if.index = CfgColumns;
    cfg_if.data  = cols;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_limit(CfgColumns, cols);
    @(negedge clk_i);
    cfg_if.index = CfgRows;
    cfg_if.data  = rows;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_limit(CfgRows, rows);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
                           input int unsigned items, input bit quiet);
    int unsigned target;
    wait_idle();
    write_limits(cols, rows);
    no_idle = quiet;
    target  = aux_items + items;
    while (aux_items < target) send_random_item();
    no_idle = 1'b0;
  endtask

  // receiver: random ready runs and stalls, plus one long hold-off on request
  initial begin
    int unsigned run_len;
    bit          run_ready;
    run_len      = 0;
    run_ready    = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        run_len  = 0;
      end
      if (run_len == 0) begin
        run_ready = ($urandom_range(99) < 60);
        if (run_ready) run_len = ($urandom_range(19) == 0) ? 200 : $urandom_range(1, 20);
        else run_len = pick_gap() + 1;
      end
      out_if.ready = run_ready;
      run_len--;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.cursor_col, out_if.cursor_row, out_if.select_event);
  end

  // watchdog on channel activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.from_aux  = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: bytes from the keyboard side are ignored
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // headers with an overflow bit are dropped
    send_byte(8'(1 << HdrOvfYBit) | 8'h09, 1'b1);
    send_byte(8'(1 << HdrOvfXBit), 1'b1);
    // left once, +127 columns runs off the right edge
    send_packet(make_header(1'b1, 1'b0, 1'b0, 1'b0), 8'h7F, 8'h00);
    // left again starts a selection, one left and one up
    send_packet(make_header(1'b1, 1'b0, 1'b1, 1'b0), 8'hFF, 8'h01);
    // release ends it, -256 on both axes stays put
    send_packet(make_header(1'b0, 1'b0, 1'b1, 1'b1), 8'h00, 8'h00);
    // right pastes now that a selection exists, five right and five down
    send_packet(make_header(1'b0, 1'b1, 1'b0, 1'b1), 8'h05, 8'hFB);
    // both buttons: left wins, +128 columns and 127 up both off screen
    send_packet(make_header(1'b1, 1'b1, 1'b0, 1'b0), 8'h80, 8'h7F);
    // right alone keeps left_held
    send_packet(make_header(1'b0, 1'b1, 1'b0, 1'b0), 8'h00, 8'h00);

    // widest screen
    run_phase(8'd255, 8'd255, 200, 1'b0);

    // hold the receiver off while the sender keeps offering packets
    wait_idle();
    hold_req   = 1'b1;
    burst_mode = 1'b1;
    repeat (BurstPackets) send_random_packet();
    burst_mode = 1'b0;
    // sender pauses until every word has come back
    wait_idle();

    run_phase(8'd1, 8'd1, 120, 1'b0);
    // limits below the cursor: position kept, only in-range moves apply
    run_phase(8'd3, 8'd2, 120, 1'b0);
    // zero limits: nothing moves
    run_phase(8'd0, 8'd0, 40, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 250, 1'b0);
    run_phase(8'd255, 8'd1, 150, 1'b1);
    run_phase(8'd1, 8'd255, 150, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 250, 1'b0);
    run_phase(ColumnsReset, RowsReset, 200, 1'b0);

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d cursor words never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
